/* rtl/tsfm_pkg.sv */
// package for the touch sample filter and screen mapper
// holds the sequencer state type, status and op codes, register indexes
// and fixed widths; no dependencies
package tsfm_pkg;

    localparam int DATA_W = 12;
    localparam int DIV_W  = 24;
    localparam int DCNT_W = 5;
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);

    localparam logic OP_PEN_UP = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] REG_RAW_X_LOW      = 3'd0;
    localparam logic [2:0] REG_RAW_X_HIGH     = 3'd1;
    localparam logic [2:0] REG_RAW_Y_LOW      = 3'd2;
    localparam logic [2:0] REG_RAW_Y_HIGH     = 3'd3;
    localparam logic [2:0] REG_SCREEN_X_LIMIT = 3'd4;
    localparam logic [2:0] REG_SCREEN_Y_LIMIT = 3'd5;
    localparam logic [2:0] REG_INVERT_MASK    = 3'd6;
    localparam logic [2:0] REG_MISMATCH_LIMIT = 3'd7;

    localparam logic [1:0] GROUP_X1 = 2'd0;
    localparam logic [1:0] GROUP_Y1 = 2'd1;
    localparam logic [1:0] GROUP_X2 = 2'd2;
    localparam logic [1:0] GROUP_Y2 = 2'd3;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef enum logic [1:0] {
        STATUS_PEN_UP   = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_ACCEPTED = 2'd2
    } tsfm_status_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_PICK     = 4'd1,
        ST_LATCH    = 4'd2,
        ST_RANK     = 4'd3,
        ST_ACC      = 4'd4,
        ST_DIV_MEAN = 4'd5,
        ST_STORE    = 4'd6,
        ST_CHECK    = 4'd7,
        ST_MAP_MUL  = 4'd8,
        ST_MAP_DIV  = 4'd9,
        ST_MAP_END  = 4'd10,
        ST_EMIT     = 4'd11
    } tsfm_state_t;

endpackage

/* rtl/touch_sample_filter_and_map.sv */
// touch sample filter and screen mapper, top level
// trimmed mean per sample group, scan stability check and calibrated mapping
// depends on tsfm_pkg
//
// usage: s_* carries one item per transaction, s_tuser is the op (0 pen up,
// 1 converter sample) and s_tdata[11:0] the sample. a scan is four groups of
// SAMPLES_PER_GROUP samples (x, y, x, y). m_* gives one result per pen-up
// event or completed scan; cfg_* writes the eight calibration registers.
// steps: a sample that does not close a group is only written to the buffer.
// a group close runs the rank loop, per sample a pick, a latch, one compare per
// cycle against a single memory read port and an accumulate, then the shared
// restoring divider and a store step. closing a scan adds a check step and per
// axis a multiply, a divide (skipped on a clamp) and a mirror before the result
// is loaded. a pen-up event goes through the emit state to the output register.
// reset clears the scan position, pressed and the held coordinates and loads
// the default calibration. a result waits in the output register while the
// receiver stalls; a following result holds the sequencer until it is taken.
module touch_sample_filter_and_map #(
    parameter int SAMPLES_PER_GROUP = 5,
    parameter int DROP_EACH_END     = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, rest zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] pressed, [12:1] raw_x_out, [24:13] raw_y_out,
                                   // [36:25] screen_x, [48:37] screen_y, rest zero
    output logic [1:0]  m_tuser,   // [1:0] scan_status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int N        = SAMPLES_PER_GROUP;
    localparam int DROP_EFF = (2 * DROP_EACH_END >= N) ? (N - 1) / 2 : DROP_EACH_END;
    localparam int KEEP     = N - 2 * DROP_EFF;
    localparam int IDX_W    = $clog2(N);
    localparam int SUM_W    = tsfm_pkg::DATA_W + $clog2(N);
    localparam logic [IDX_W-1:0] N_LAST   = IDX_W'(N - 1);
    localparam logic [IDX_W:0]   RANK_LO  = (IDX_W + 1)'(DROP_EFF);
    localparam logic [IDX_W:0]   RANK_HI  = (IDX_W + 1)'(N - DROP_EFF);
    localparam logic [11:0]      KEEP_DEN = 12'(KEEP);

    // calibration registers
    logic [11:0] raw_x_low_reg, raw_x_high_reg, raw_y_low_reg, raw_y_high_reg;
    logic [11:0] screen_x_limit_reg, screen_y_limit_reg, mismatch_limit_reg;
    logic [1:0]  invert_mask_reg;

    tsfm_pkg::tsfm_state_t state_reg, state_next;

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [1:0]       group_reg, group_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [IDX_W-1:0] rank_reg, rank_next;
    logic [11:0]      cur_reg, cur_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [tsfm_pkg::DIV_W-1:0]  quot_reg, quot_next;
    logic [11:0]                 rem_reg, rem_next;
    logic [11:0]                 den_reg, den_next;
    logic [tsfm_pkg::DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [11:0] fx_reg, fx_next, fy_reg, fy_next, sx_reg, sx_next, sy_reg, sy_next;
    logic        axis_reg, axis_next;
    logic [1:0]  status_reg, status_next;
    logic        pressed_reg, pressed_next;
    logic [11:0] held_raw_x_reg, held_raw_x_next, held_raw_y_reg, held_raw_y_next;
    logic [11:0] held_scr_x_reg, held_scr_x_next, held_scr_y_reg, held_scr_y_next;
    logic        out_valid_reg, out_valid_next;
    logic [55:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;

    // sample buffer, one write port and one registered read port
    logic [11:0]      mem [N];
    logic [IDX_W-1:0] rd_addr;
    logic [11:0]      rd_data_reg;

    logic s_accept;
    logic out_free;
    logic rank_less;
    logic include_cur;
    logic [SUM_W-1:0] sum_inc;
    logic [12:0] rem_sh, rem_sub;
    logic [11:0] diff_x, diff_y;
    logic        reject;
    logic [11:0] map_raw, map_lo, map_hi, map_lim, map_val, map_out;
    logic        map_mirror, map_low_clamp, map_high_clamp;
    logic [12:0] pair_x, pair_y;

    assign s_tready  = (state_reg == tsfm_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_x_low_reg      <= 12'd200;
            raw_x_high_reg     <= 12'd3900;
            raw_y_low_reg      <= 12'd200;
            raw_y_high_reg     <= 12'd3900;
            screen_x_limit_reg <= 12'd319;
            screen_y_limit_reg <= 12'd479;
            invert_mask_reg    <= 2'd1;
            mismatch_limit_reg <= 12'd80;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tsfm_pkg::REG_RAW_X_LOW:      raw_x_low_reg      <= cfg_data;
                tsfm_pkg::REG_RAW_X_HIGH:     raw_x_high_reg     <= cfg_data;
                tsfm_pkg::REG_RAW_Y_LOW:      raw_y_low_reg      <= cfg_data;
                tsfm_pkg::REG_RAW_Y_HIGH:     raw_y_high_reg     <= cfg_data;
                tsfm_pkg::REG_SCREEN_X_LIMIT: screen_x_limit_reg <= cfg_data;
                tsfm_pkg::REG_SCREEN_Y_LIMIT: screen_y_limit_reg <= cfg_data;
                tsfm_pkg::REG_INVERT_MASK:    invert_mask_reg    <= cfg_data[1:0];
                tsfm_pkg::REG_MISMATCH_LIMIT: mismatch_limit_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s_tuser == tsfm_pkg::OP_SAMPLE)
        begin
            mem[pos_reg] <= s_tdata[11:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        rd_addr = '0;
        unique case (state_reg)
            tsfm_pkg::ST_PICK: rd_addr = i_reg;
            tsfm_pkg::ST_RANK: rd_addr = (j_reg == N_LAST) ? '0 : j_reg + 1'b1;
            default:           rd_addr = '0;
        endcase
    end

    // shared compare, divide step, stability check and per-axis selection
    always_comb
    begin
        rank_less   = (rd_data_reg < cur_reg) || (rd_data_reg == cur_reg && j_reg < i_reg);
        include_cur = ({1'b0, rank_reg} >= RANK_LO) && ({1'b0, rank_reg} < RANK_HI);
        sum_inc     = sum_reg + (include_cur ? SUM_W'(cur_reg) : '0);

        rem_sh  = {rem_reg, quot_reg[tsfm_pkg::DIV_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};

        diff_x = (fx_reg > sx_reg) ? fx_reg - sx_reg : sx_reg - fx_reg;
        diff_y = (fy_reg > sy_reg) ? fy_reg - sy_reg : sy_reg - fy_reg;
        reject = (diff_x > mismatch_limit_reg) || (diff_y > mismatch_limit_reg);
        pair_x = {1'b0, fx_reg} + {1'b0, sx_reg};
        pair_y = {1'b0, fy_reg} + {1'b0, sy_reg};

        if (axis_reg == tsfm_pkg::AXIS_X)
        begin
            map_raw    = held_raw_x_reg;
            map_lo     = raw_x_low_reg;
            map_hi     = raw_x_high_reg;
            map_lim    = screen_x_limit_reg;
            map_mirror = invert_mask_reg[0];
        end
        else
        begin
            map_raw    = held_raw_y_reg;
            map_lo     = raw_y_low_reg;
            map_hi     = raw_y_high_reg;
            map_lim    = screen_y_limit_reg;
            map_mirror = invert_mask_reg[1];
        end
        map_low_clamp  = (map_raw <= map_lo);
        map_high_clamp = (map_raw >= map_hi);
        map_val        = quot_reg[11:0];
        map_out        = map_mirror ? map_lim - map_val : map_val;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsfm_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == tsfm_pkg::OP_PEN_UP)
                        state_next = tsfm_pkg::ST_EMIT;
                    else if (pos_reg == N_LAST)
                        state_next = tsfm_pkg::ST_PICK;
                end
            end
            tsfm_pkg::ST_PICK:  state_next = tsfm_pkg::ST_LATCH;
            tsfm_pkg::ST_LATCH: state_next = tsfm_pkg::ST_RANK;
            tsfm_pkg::ST_RANK:
            begin
                if (j_reg == N_LAST)
                    state_next = tsfm_pkg::ST_ACC;
            end
            tsfm_pkg::ST_ACC:
            begin
                state_next = (i_reg == N_LAST) ? tsfm_pkg::ST_DIV_MEAN : tsfm_pkg::ST_PICK;
            end
            tsfm_pkg::ST_DIV_MEAN:
            begin
                if (dcnt_reg == tsfm_pkg::DIV_LAST)
                    state_next = tsfm_pkg::ST_STORE;
            end
            tsfm_pkg::ST_STORE:
            begin
                state_next = (group_reg == tsfm_pkg::GROUP_Y2) ? tsfm_pkg::ST_CHECK
                                                               : tsfm_pkg::ST_IDLE;
            end
            tsfm_pkg::ST_CHECK:
            begin
                state_next = reject ? tsfm_pkg::ST_EMIT : tsfm_pkg::ST_MAP_MUL;
            end
            tsfm_pkg::ST_MAP_MUL:
            begin
                state_next = (map_low_clamp || map_high_clamp) ? tsfm_pkg::ST_MAP_END
                                                               : tsfm_pkg::ST_MAP_DIV;
            end
            tsfm_pkg::ST_MAP_DIV:
            begin
                if (dcnt_reg == tsfm_pkg::DIV_LAST)
                    state_next = tsfm_pkg::ST_MAP_END;
            end
            tsfm_pkg::ST_MAP_END:
            begin
                state_next = (axis_reg == tsfm_pkg::AXIS_X) ? tsfm_pkg::ST_MAP_MUL
                                                            : tsfm_pkg::ST_EMIT;
            end
            tsfm_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = tsfm_pkg::ST_IDLE;
            end
            default: state_next = tsfm_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pos_next        = pos_reg;
        group_next      = group_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        rank_next       = rank_reg;
        cur_next        = cur_reg;
        sum_next        = sum_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        dcnt_next       = dcnt_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        axis_next       = axis_reg;
        status_next     = status_reg;
        pressed_next    = pressed_reg;
        held_raw_x_next = held_raw_x_reg;
        held_raw_y_next = held_raw_y_reg;
        held_scr_x_next = held_scr_x_reg;
        held_scr_y_next = held_scr_y_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;

        unique case (state_reg)
            tsfm_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == tsfm_pkg::OP_PEN_UP)
                    begin
                        pos_next     = '0;
                        group_next   = tsfm_pkg::GROUP_X1;
                        pressed_next = 1'b0;
                        status_next  = tsfm_pkg::STATUS_PEN_UP;
                    end
                    else if (pos_reg == N_LAST)
                    begin
                        pos_next = '0;
                        i_next   = '0;
                        sum_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            tsfm_pkg::ST_PICK: ;
            tsfm_pkg::ST_LATCH:
            begin
                cur_next  = rd_data_reg;
                j_next    = '0;
                rank_next = '0;
            end
            tsfm_pkg::ST_RANK:
            begin
                // rank with ties broken by position gives a permutation
                if (rank_less)
                    rank_next = rank_reg + 1'b1;
                j_next = j_reg + 1'b1;
            end
            tsfm_pkg::ST_ACC:
            begin
                if (i_reg == N_LAST)
                begin
                    quot_next = tsfm_pkg::DIV_W'(sum_inc);
                    rem_next  = '0;
                    den_next  = KEEP_DEN;
                    dcnt_next = '0;
                    sum_next  = '0;
                end
                else
                begin
                    sum_next = sum_inc;
                    i_next   = i_reg + 1'b1;
                end
            end
            tsfm_pkg::ST_DIV_MEAN, tsfm_pkg::ST_MAP_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (!rem_sub[12])
                begin
                    rem_next  = rem_sub[11:0];
                    quot_next = {quot_reg[tsfm_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[11:0];
                    quot_next = {quot_reg[tsfm_pkg::DIV_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
            end
            tsfm_pkg::ST_STORE:
            begin
                unique case (group_reg)
                    tsfm_pkg::GROUP_X1: fx_next = quot_reg[11:0];
                    tsfm_pkg::GROUP_Y1: fy_next = quot_reg[11:0];
                    tsfm_pkg::GROUP_X2: sx_next = quot_reg[11:0];
                    tsfm_pkg::GROUP_Y2: sy_next = quot_reg[11:0];
                    default:            ;
                endcase
                group_next = group_reg + 1'b1;
            end
            tsfm_pkg::ST_CHECK:
            begin
                if (reject)
                begin
                    status_next = tsfm_pkg::STATUS_REJECTED;
                end
                else
                begin
                    held_raw_x_next = pair_x[12:1];
                    held_raw_y_next = pair_y[12:1];
                    axis_next       = tsfm_pkg::AXIS_X;
                end
            end
            tsfm_pkg::ST_MAP_MUL:
            begin
                if (map_low_clamp)
                begin
                    quot_next = '0;
                end
                else if (map_high_clamp)
                begin
                    quot_next = tsfm_pkg::DIV_W'(map_lim);
                end
                else
                begin
                    quot_next = {12'd0, map_raw - map_lo} * {12'd0, map_lim};
                    den_next  = map_hi - map_lo;
                    rem_next  = '0;
                    dcnt_next = '0;
                end
            end
            tsfm_pkg::ST_MAP_END:
            begin
                if (axis_reg == tsfm_pkg::AXIS_X)
                begin
                    held_scr_x_next = map_out;
                    axis_next       = tsfm_pkg::AXIS_Y;
                end
                else
                begin
                    held_scr_y_next = map_out;
                    pressed_next    = 1'b1;
                    status_next     = tsfm_pkg::STATUS_ACCEPTED;
                end
            end
            tsfm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, held_scr_y_reg, held_scr_x_reg,
                                      held_raw_y_reg, held_raw_x_reg, pressed_reg};
                    out_user_next  = status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tsfm_pkg::ST_IDLE;
            pos_reg        <= '0;
            group_reg      <= tsfm_pkg::GROUP_X1;
            pressed_reg    <= 1'b0;
            held_raw_x_reg <= '0;
            held_raw_y_reg <= '0;
            held_scr_x_reg <= '0;
            held_scr_y_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            group_reg      <= group_next;
            pressed_reg    <= pressed_next;
            held_raw_x_reg <= held_raw_x_next;
            held_raw_y_reg <= held_raw_y_next;
            held_scr_x_reg <= held_scr_x_next;
            held_scr_y_reg <= held_scr_y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        rank_reg     <= rank_next;
        cur_reg      <= cur_next;
        sum_reg      <= sum_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        dcnt_reg     <= dcnt_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        axis_reg     <= axis_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

/* tb/tb_touch_sample_filter_and_map.sv */
// self-checking testbench for touch_sample_filter_and_map: directed table, then
// shaped random scans under several calibrations and idling mixes
// depends on tsfm_pkg and the rtl top level
module tb_touch_sample_filter_and_map;

    localparam int NS   = 5;
    localparam int DROP = 1;

    typedef struct packed {
        logic                   pressed;
        tsfm_pkg::tsfm_status_t status;
        logic [11:0]            raw_x;
        logic [11:0]            raw_y;
        logic [11:0]            scr_x;
        logic [11:0]            scr_y;
    } touch_report_t;

    typedef struct packed {
        logic          op;
        logic [11:0]   smp;
        logic [4:0]    reps;
        logic          typed;
        touch_report_t want;
    } directed_row_t;

    typedef struct {
        logic [11:0] x_lo;
        logic [11:0] x_hi;
        logic [11:0] y_lo;
        logic [11:0] y_hi;
        logic [11:0] x_lim;
        logic [11:0] y_lim;
        logic [1:0]  inv;
        logic [11:0] mism;
    } cal_set_t;

    localparam touch_report_t RESET_REPORT =
        '{1'b0, tsfm_pkg::STATUS_PEN_UP, 12'd0, 12'd0, 12'd0, 12'd0};
    // full-scale x, zero y: x clamps high then mirrors to zero, y clamps low
    localparam touch_report_t EXTREME_SCAN_REPORT =
        '{1'b1, tsfm_pkg::STATUS_ACCEPTED, 12'hFFF, 12'd0, 12'd0, 12'd0};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    touch_sample_filter_and_map #(
        .SAMPLES_PER_GROUP(NS),
        .DROP_EACH_END    (DROP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    cal_set_t     cal;
    logic [11:0]  grp_buf [NS];
    int unsigned  scan_count;
    int unsigned  rd_x1, rd_y1, rd_x2;
    logic         pen_pressed;
    logic [11:0]  held_raw_x, held_raw_y, held_scr_x, held_scr_y;

    touch_report_t pending_reports [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int reports_seen = 0;
    int n_accepted   = 0;
    int n_rejected   = 0;
    int n_pen_up     = 0;
    int mismatches   = 0;

    function automatic int unsigned trimmed_group_mean();
        int unsigned v [NS];
        int unsigned drop, sum, t;
        int i, j;
        drop = (2 * DROP >= NS) ? (NS - 1) / 2 : DROP;
        sum = 0;
        for (i = 0; i < NS; i++)
            v[i] = grp_buf[i];
        for (i = 0; i < NS - 1; i++)
            for (j = i + 1; j < NS; j++)
                if (v[i] > v[j])
                begin
                    t = v[i];
                    v[i] = v[j];
                    v[j] = t;
                end
        for (i = drop; i < NS - drop; i++)
            sum += v[i];
        return (sum / (NS - 2 * drop)) & 12'hFFF;
    endfunction

    function automatic logic [11:0] map_to_screen(input int unsigned raw, input int unsigned lo,
                                                  input int unsigned hi, input int unsigned lim,
                                                  input logic mirror);
        int unsigned val;
        if (raw <= lo)
            val = 0;
        else if (raw >= hi)
            val = lim;
        else
            val = ((raw - lo) * lim) / (hi - lo);
        if (mirror)
            val = lim - val;
        return val[11:0];
    endfunction

    function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic predict_touch_report(input logic op, input logic [11:0] smp,
                                        output bit produced, output touch_report_t rpt);
        int unsigned pos, grp, m;
        tsfm_pkg::tsfm_status_t status;
        produced = 1'b0;
        status = tsfm_pkg::STATUS_PEN_UP;
        if (op == tsfm_pkg::OP_PEN_UP)
        begin
            scan_count = 0;
            pen_pressed = 1'b0;
            produced = 1'b1;
        end
        else
        begin
            pos = scan_count % NS;
            grp = scan_count / NS;
            grp_buf[pos] = smp;
            scan_count++;
            if (pos + 1 == NS)
            begin
                m = trimmed_group_mean();
                case (grp)
                    tsfm_pkg::GROUP_X1: rd_x1 = m;
                    tsfm_pkg::GROUP_Y1: rd_y1 = m;
                    tsfm_pkg::GROUP_X2: rd_x2 = m;
                    default:
                    begin
                        scan_count = 0;
                        produced = 1'b1;
                        if (abs_gap(rd_x1, rd_x2) > cal.mism || abs_gap(rd_y1, m) > cal.mism)
                            status = tsfm_pkg::STATUS_REJECTED;
                        else
                        begin
                            held_raw_x = 12'((rd_x1 + rd_x2) / 2);
                            held_raw_y = 12'((rd_y1 + m) / 2);
                            held_scr_x = map_to_screen(held_raw_x, cal.x_lo, cal.x_hi,
                                                       cal.x_lim, cal.inv[0]);
                            held_scr_y = map_to_screen(held_raw_y, cal.y_lo, cal.y_hi,
                                                       cal.y_lim, cal.inv[1]);
                            pen_pressed = 1'b1;
                            status = tsfm_pkg::STATUS_ACCEPTED;
                        end
                    end
                endcase
            end
        end
        rpt = '{pen_pressed, status, held_raw_x, held_raw_y, held_scr_x, held_scr_y};
    endtask

    // valid stays high across back-to-back transactions, only dropped in a gap
    task automatic send_touch_item(input logic op, input logic [11:0] smp,
                                   input logic typed, input touch_report_t want);
        touch_report_t predicted;
        bit produced;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_touch_report(op, smp, produced, predicted);
        if (produced)
            pending_reports.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic write_cal_reg(input logic [2:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tsfm_pkg::REG_RAW_X_LOW:      cal.x_lo  = val;
            tsfm_pkg::REG_RAW_X_HIGH:     cal.x_hi  = val;
            tsfm_pkg::REG_RAW_Y_LOW:      cal.y_lo  = val;
            tsfm_pkg::REG_RAW_Y_HIGH:     cal.y_hi  = val;
            tsfm_pkg::REG_SCREEN_X_LIMIT: cal.x_lim = val;
            tsfm_pkg::REG_SCREEN_Y_LIMIT: cal.y_lim = val;
            tsfm_pkg::REG_INVERT_MASK:    cal.inv   = val[1:0];
            default:                      cal.mism  = val;
        endcase
    endtask

    task automatic load_calibration(input cal_set_t c);
        write_cal_reg(tsfm_pkg::REG_RAW_X_LOW, c.x_lo);
        write_cal_reg(tsfm_pkg::REG_RAW_X_HIGH, c.x_hi);
        write_cal_reg(tsfm_pkg::REG_RAW_Y_LOW, c.y_lo);
        write_cal_reg(tsfm_pkg::REG_RAW_Y_HIGH, c.y_hi);
        write_cal_reg(tsfm_pkg::REG_SCREEN_X_LIMIT, c.x_lim);
        write_cal_reg(tsfm_pkg::REG_SCREEN_Y_LIMIT, c.y_lim);
        write_cal_reg(tsfm_pkg::REG_INVERT_MASK, {10'd0, c.inv});
        write_cal_reg(tsfm_pkg::REG_MISMATCH_LIMIT, c.mism);
        cfg_valid <= 1'b0;
    endtask

    function automatic cal_set_t random_calibration();
        cal_set_t c;
        c.x_lo  = 12'($urandom_range(0, 4095));
        c.x_hi  = 12'($urandom_range(0, 4095));
        c.y_lo  = 12'($urandom_range(0, 4095));
        c.y_hi  = 12'($urandom_range(0, 4095));
        c.x_lim = 12'($urandom_range(0, 4095));
        c.y_lim = 12'($urandom_range(0, 4095));
        c.inv   = 2'($urandom_range(0, 3));
        c.mism  = 12'($urandom_range(0, 200));
        return c;
    endfunction

    // drain results, then allow for a group close still in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [11:0] clip_sample(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'hFFF;
        return 12'(v);
    endfunction

    // offset of the second reading, biased to land on the mismatch boundary
    function automatic int reading_offset();
        int lim;
        lim = int'(cal.mism);
        case ($urandom_range(0, 3))
            0:       return lim;
            1:       return -(lim + 1);
            default: return int'($urandom_range(0, 2 * lim + 6)) - (lim + 3);
        endcase
    endfunction

    task automatic run_shaped_scan(input int groups);
        int centers [4];
        int spread, odd_one, g, i;
        logic [11:0] smp;
        centers[0] = int'($urandom_range(0, 4095));
        centers[1] = int'($urandom_range(0, 4095));
        centers[2] = centers[0] + reading_offset();
        centers[3] = centers[1] + reading_offset();
        for (g = 0; g < groups; g++)
        begin
            case ($urandom_range(0, 2))
                0:       spread = 0;
                1:       spread = 2;
                default: spread = 30;
            endcase
            odd_one = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, NS - 1)) : -1;
            for (i = 0; i < NS; i++)
            begin
                if (i == odd_one)
                    smp = 12'($urandom_range(0, 4095));
                else
                    smp = clip_sample(centers[g] + int'($urandom_range(0, 2 * spread)) - spread);
                send_touch_item(tsfm_pkg::OP_SAMPLE, smp, 1'b0, RESET_REPORT);
            end
        end
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_touch_item(tsfm_pkg::OP_SAMPLE, 12'($urandom_range(0, 4095)), 1'b0,
                            RESET_REPORT);
    endtask

    task automatic run_random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            run_shaped_scan(4);
        else if (pick < 78)
            send_noise(4 * NS);
        else if (pick < 86)
        begin
            // scan aborted part way by the pen lifting
            if ($urandom_range(0, 1))
                run_shaped_scan($urandom_range(1, 3));
            else
                send_noise($urandom_range(1, 4 * NS - 1));
            send_touch_item(tsfm_pkg::OP_PEN_UP, 12'($urandom_range(0, 4095)), 1'b0,
                            RESET_REPORT);
        end
        else if (pick < 93)
            send_touch_item(tsfm_pkg::OP_PEN_UP, 12'($urandom_range(0, 4095)), 1'b0,
                            RESET_REPORT);
        else
            send_noise($urandom_range(1, 4));
    endtask

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_report();
        touch_report_t want;
        reports_seen++;
        case (m_tuser)
            tsfm_pkg::STATUS_ACCEPTED: n_accepted++;
            tsfm_pkg::STATUS_REJECTED: n_rejected++;
            default:                   n_pen_up++;
        endcase
        if (pending_reports.size() == 0)
        begin
            $display("%0t: unexpected report, expected none actual tuser %0d tdata %h",
                     $time, m_tuser, m_tdata);
            mismatches++;
        end
        else
        begin
            want = pending_reports.pop_front();
            compare_field("pressed", {11'd0, want.pressed}, {11'd0, m_tdata[0]});
            compare_field("scan_status", {10'd0, want.status}, {10'd0, m_tuser});
            compare_field("raw_x_out", want.raw_x, m_tdata[12:1]);
            compare_field("raw_y_out", want.raw_y, m_tdata[24:13]);
            compare_field("screen_x", want.scr_x, m_tdata[36:25]);
            compare_field("screen_y", want.scr_y, m_tdata[48:37]);
        end
    endtask

    // result side
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                check_report();
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout waiting for results");
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        directed_row_t directed_rows [9];
        cal_set_t      cal_presets [4];
        int r, k, phase, phase_start;

        directed_rows = '{
            '{tsfm_pkg::OP_PEN_UP, 12'h000, 5'd1, 1'b1, RESET_REPORT},
            '{tsfm_pkg::OP_SAMPLE, 12'h5A5, 5'd1, 1'b0, RESET_REPORT},
            '{tsfm_pkg::OP_SAMPLE, 12'hA5A, 5'd1, 1'b0, RESET_REPORT},
            '{tsfm_pkg::OP_SAMPLE, 12'h000, 5'd1, 1'b0, RESET_REPORT},
            '{tsfm_pkg::OP_PEN_UP, 12'hFFF, 5'd1, 1'b1, RESET_REPORT},
            '{tsfm_pkg::OP_SAMPLE, 12'hFFF, 5'(NS), 1'b0, RESET_REPORT},
            '{tsfm_pkg::OP_SAMPLE, 12'h000, 5'(NS), 1'b0, RESET_REPORT},
            '{tsfm_pkg::OP_SAMPLE, 12'hFFF, 5'(NS), 1'b0, RESET_REPORT},
            '{tsfm_pkg::OP_SAMPLE, 12'h000, 5'(NS), 1'b1, EXTREME_SCAN_REPORT}
        };
        cal_presets = '{
            '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, 2'd0, 12'd4095},
            '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 2'd3, 12'd0},
            '{12'd1000, 12'd3000, 12'd500, 12'd3500, 12'd1023, 12'd767, 2'd2, 12'd40},
            '{12'd2048, 12'd2048, 12'd0, 12'd1, 12'd4095, 12'd1, 2'd1, 12'd1}
        };

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 16'd0;
        s_tuser   = tsfm_pkg::OP_PEN_UP;
        cfg_valid = 1'b0;
        cfg_index = tsfm_pkg::REG_RAW_X_LOW;
        cfg_data  = 12'd0;

        cal = '{12'd200, 12'd3900, 12'd200, 12'd3900, 12'd319, 12'd479, 2'd1, 12'd80};
        for (k = 0; k < NS; k++)
            grp_buf[k] = 12'd0;
        scan_count  = 0;
        rd_x1       = 0;
        rd_y1       = 0;
        rd_x2       = 0;
        pen_pressed = 1'b0;
        held_raw_x  = 12'd0;
        held_raw_y  = 12'd0;
        held_scr_x  = 12'd0;
        held_scr_y  = 12'd0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset calibration
        for (r = 0; r < 9; r++)
            for (k = 0; k < directed_rows[r].reps; k++)
                send_touch_item(directed_rows[r].op, directed_rows[r].smp,
                                directed_rows[r].typed && (k == directed_rows[r].reps - 1),
                                directed_rows[r].want);

        for (phase = 1; phase <= 8; phase++)
        begin
            settle();
            if (phase <= 4)
                load_calibration(cal_presets[phase - 1]);
            else
                load_calibration(random_calibration());
            case (phase % 4)
                1:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                3:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 160)
                run_random_sequence();
        end
        settle();

        $display("sent %0d items over 8 calibrations and 4 idling mixes", items_sent);
        $display("checked %0d reports: %0d accepted, %0d rejected, %0d pen-up",
                 reports_seen, n_accepted, n_rejected, n_pen_up);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
